// ----- src/csp_pkg.sv -----
// shared constants and types for the cardinal spline point evaluator
package csp_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_BITS     = 16;
   localparam int LOC_BITS       = 17;
   localparam int FRAC_BITS      = 16;
   localparam int INDEX_BITS     = 6;
   localparam int BEND_BITS      = 16;
   localparam int NUM_BITS       = 7;
   localparam int H_BITS         = 18;
   localparam int SUM_BITS       = 56;
   localparam logic [LOC_BITS-1:0] LOC_ONE = LOC_BITS'(1 << FRAC_BITS);

   localparam logic [1:0] CSR_NUM_POINTS  = 2'd0;
   localparam logic [1:0] CSR_CLOSED_MODE = 2'd1;
   localparam logic [1:0] CSR_BEND_SIZE   = 2'd2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_EVAL  = 1'b1;

   typedef struct packed {
      logic ld4;
      logic ld5;
      logic ld6;
      logic ld7;
      logic ld8;
   } stage_en_type;

endpackage

// ----- src/csp_axis.sv -----
// per-axis tangent, basis mix and truncate/saturate stages
module csp_axis
   import csp_pkg::*;
(
   input  logic                          clock,
   input  stage_en_type                  en,
   input  logic [BEND_BITS-1:0]          bend,
   input  logic signed [COORD_BITS-1:0]  p0,
   input  logic signed [COORD_BITS-1:0]  p1,
   input  logic signed [COORD_BITS-1:0]  p2,
   input  logic signed [COORD_BITS-1:0]  pm,
   input  logic signed [H_BITS-1:0]      h1,
   input  logic signed [H_BITS-1:0]      h2,
   input  logic signed [H_BITS-1:0]      h3,
   input  logic signed [H_BITS-1:0]      h4,
   output logic signed [COORD_BITS-1:0]  result
);

   localparam int DW = COORD_BITS + 1;
   localparam int VW = DW + BEND_BITS + 1;
   localparam int AW = H_BITS + COORD_BITS;
   localparam int CW = H_BITS + VW;
   localparam logic [SUM_BITS-1:0] SAT_HI = SUM_BITS'((1 << (COORD_BITS - 1)) - 1);
   localparam logic [SUM_BITS-1:0] SAT_LO = SUM_BITS'(1 << (COORD_BITS - 1));

   logic signed [DW-1:0] d1_ff, d2_ff;
   logic signed [COORD_BITS-1:0] p0_4_ff, p1_4_ff, p0_5_ff, p1_5_ff;
   logic signed [VW-1:0] v1_ff, v2_ff;
   logic signed [AW-1:0] ta_ff, tb_ff;
   logic signed [CW-1:0] tc_ff, td_ff;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;
   logic signed [COORD_BITS-1:0] res_ff, res_in;
   logic signed [BEND_BITS:0] bend_s;
   logic [SUM_BITS-1:0] mag, q;

   assign bend_s = $signed({1'b0, bend});

   always_ff @(posedge clock) begin
      if (en.ld4) begin
         d1_ff   <= DW'(p1) - DW'(pm);
         d2_ff   <= DW'(p2) - DW'(p0);
         p0_4_ff <= p0;
         p1_4_ff <= p1;
      end
      if (en.ld5) begin
         v1_ff   <= VW'(bend_s) * VW'(d1_ff);
         v2_ff   <= VW'(bend_s) * VW'(d2_ff);
         p0_5_ff <= p0_4_ff;
         p1_5_ff <= p1_4_ff;
      end
      if (en.ld6) begin
         ta_ff <= AW'(h1) * AW'(p0_5_ff);
         tb_ff <= AW'(h2) * AW'(p1_5_ff);
         tc_ff <= CW'(h3) * CW'(v1_ff);
         td_ff <= CW'(h4) * CW'(v2_ff);
      end
      if (en.ld7) begin
         sum_ff <= sum_in;
      end
      if (en.ld8) begin
         res_ff <= res_in;
      end
   end

   always_comb begin
      sum_in = ((SUM_BITS'(ta_ff) + SUM_BITS'(tb_ff)) <<< 14)
               + SUM_BITS'(tc_ff) + SUM_BITS'(td_ff);
   end

   // truncate toward zero, then clamp to the coordinate range
   always_comb begin
      mag = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
      q   = mag >> 30;
      if (sum_ff[SUM_BITS-1]) begin
         if (q > SAT_LO) res_in = COORD_BITS'(-SAT_LO);
         else res_in = COORD_BITS'(-q);
      end else begin
         if (q > SAT_HI) res_in = COORD_BITS'(SAT_HI);
         else res_in = COORD_BITS'(q);
      end
   end

   assign result = res_ff;

endmodule

// ----- src/cardinal_spline_point_eval.sv -----
// Cardinal spline point evaluator: a write item (tuser 0) stores one control point, an
// evaluate item (tuser 1) returns one interpolated x/y/z result. The pipeline takes one
// item every cycle unless rsp_tready backpressure stalls it; its eight register
// stages (segment multiply, index and f^2, four-port point table read, f^3, basis and
// tangent multiplies, term multiplies, sum, truncate/saturate) each hold a valid bit and
// stall individually, so bubbles are squeezed out under rsp_tready backpressure. The point
// table is four copies of a MAX_POINTS-entry memory, one per neighbor read. Configuration
// writes are taken in any cycle but must only happen while no item is in flight.
module cardinal_spline_point_eval
   import csp_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // point_index[5:0], point_x[21:6], point_y[37:22], point_z[53:38], location[70:54], 0
   input  logic [71:0] req_tdata,
   // func[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_x[15:0], out_y[31:16], out_z[47:32]
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int PW = LOC_BITS + CW;
   localparam int PTW = 3 * COORD_BITS;

   logic [NUM_BITS-1:0]  num_points_ff;
   logic                 closed_ff;
   logic [BEND_BITS-1:0] bend_ff;

   logic [8:1] v_ff;
   logic [8:1] ld;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= NUM_BITS'(1);
         closed_ff     <= 1'b0;
         bend_ff       <= BEND_BITS'(8192);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_POINTS:  num_points_ff <= csr_data[NUM_BITS-1:0];
            CSR_CLOSED_MODE: closed_ff     <= csr_data[0];
            CSR_BEND_SIZE:   bend_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   // a stage loads when empty or when the stage after it moves
   always_comb begin
      ld[8] = !v_ff[8] || rsp_tready;
      for (int k = 7; k >= 1; k--) ld[k] = !v_ff[k] || ld[k+1];
   end
   assign req_tready = ld[1];

   // ---- stage 1: count, clamp location, segment product
   logic [CW-1:0] cnt, cnt_ff;
   logic [CW-1:0] nseg;
   logic [LOC_BITS-1:0] loc;
   logic [PW-1:0] prod_ff;
   logic func_1_ff;
   logic [INDEX_BITS-1:0] idx_1_ff;
   logic [PTW-1:0] pt_1_ff;

   always_comb begin
      if (num_points_ff == '0) cnt = CW'(1);
      else if (32'(num_points_ff) > 32'(MAX_POINTS)) cnt = CW'(MAX_POINTS);
      else cnt = CW'(num_points_ff);
      nseg = closed_ff ? cnt : cnt - CW'(1);
      loc  = req_tdata[70:54];
      if (loc > LOC_ONE) loc = LOC_ONE;
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         prod_ff   <= PW'(loc) * PW'(nseg);
         cnt_ff    <= cnt;
         func_1_ff <= req_tuser[0];
         idx_1_ff  <= req_tdata[5:0];
         pt_1_ff   <= req_tdata[53:6];
      end
   end

   // ---- stage 2: neighbor indices and f^2
   logic [CW:0] seg, last, i0, i1, i2, i3;
   logic [FRAC_BITS-1:0] f;
   logic [AW-1:0] a0_ff, a1_ff, a2_ff, a3_ff;
   logic [FRAC_BITS-1:0] f_2_ff, f2_2_ff;
   logic [2*FRAC_BITS-1:0] ff_prod;
   logic func_2_ff, wr_ok_2_ff;
   logic [AW-1:0] waddr_2_ff;
   logic [PTW-1:0] pt_2_ff;
   logic [31:0] idx_ext;

   always_comb begin
      seg  = (CW+1)'(prod_ff >> FRAC_BITS);
      f    = prod_ff[FRAC_BITS-1:0];
      last = (CW+1)'(cnt_ff) - (CW+1)'(1);
      if (closed_ff) begin
         i0 = (seg == (CW+1)'(cnt_ff)) ? '0 : seg;
         i1 = i0 + (CW+1)'(1);
         if (i1 >= (CW+1)'(cnt_ff)) i1 = i1 - (CW+1)'(cnt_ff);
         i2 = i0 + (CW+1)'(2);
         if (i2 >= (CW+1)'(cnt_ff)) i2 = i2 - (CW+1)'(cnt_ff);
         if (cnt_ff == CW'(1)) i2 = '0;
         i3 = (i0 == '0) ? last : i0 - (CW+1)'(1);
      end else begin
         i0 = (seg > last) ? last : seg;
         i1 = (i0 + (CW+1)'(1) > last) ? last : i0 + (CW+1)'(1);
         i2 = (i0 + (CW+1)'(2) > last) ? last : i0 + (CW+1)'(2);
         i3 = (i0 == '0) ? '0 : i0 - (CW+1)'(1);
      end
      ff_prod = 32'(f) * 32'(f);
      idx_ext = 32'(idx_1_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         a0_ff      <= i0[AW-1:0];
         a1_ff      <= i1[AW-1:0];
         a2_ff      <= i2[AW-1:0];
         a3_ff      <= i3[AW-1:0];
         f_2_ff     <= f;
         f2_2_ff    <= ff_prod[2*FRAC_BITS-1:FRAC_BITS];
         func_2_ff  <= func_1_ff;
         wr_ok_2_ff <= idx_ext < 32'(MAX_POINTS);
         waddr_2_ff <= idx_ext[AW-1:0];
         pt_2_ff    <= pt_1_ff;
      end
   end

   // ---- stage 3: point table, one copy per neighbor; writes take effect in order here
   logic wr_en;
   logic [AW-1:0] raddr [4];
   logic [PTW-1:0] rd_ff [4];
   logic [FRAC_BITS-1:0] f_3_ff, f2_3_ff;

   assign wr_en = ld[3] && v_ff[2] && (func_2_ff == FUNC_WRITE) && wr_ok_2_ff;
   assign raddr[0] = a0_ff;
   assign raddr[1] = a1_ff;
   assign raddr[2] = a2_ff;
   assign raddr[3] = a3_ff;

   for (genvar m = 0; m < 4; m++) begin : g_mem
      logic [PTW-1:0] mem [MAX_POINTS];
      always_ff @(posedge clock) begin
         if (wr_en) mem[waddr_2_ff] <= pt_2_ff;
         if (ld[3]) rd_ff[m] <= mem[raddr[m]];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         f_3_ff  <= f_2_ff;
         f2_3_ff <= f2_2_ff;
      end
   end

   // ---- stage 4: f^3
   logic [FRAC_BITS-1:0] f_4_ff, f2_4_ff, f3_4_ff;
   logic [2*FRAC_BITS-1:0] f3_prod;
   assign f3_prod = 32'(f2_3_ff) * 32'(f_3_ff);

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         f_4_ff  <= f_3_ff;
         f2_4_ff <= f2_3_ff;
         f3_4_ff <= f3_prod[2*FRAC_BITS-1:FRAC_BITS];
      end
   end

   // ---- stage 5: hermite basis
   logic signed [H_BITS-1:0] h1_ff, h2_ff, h3_ff, h4_ff;
   logic signed [H_BITS-1:0] sf, sf2, sf3;
   assign sf  = $signed(H_BITS'(f_4_ff));
   assign sf2 = $signed(H_BITS'(f2_4_ff));
   assign sf3 = $signed(H_BITS'(f3_4_ff));

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         h1_ff <= (sf3 <<< 1) - (sf2 <<< 1) - sf2 + H_BITS'(1 << FRAC_BITS);
         h2_ff <= (sf2 <<< 1) + sf2 - (sf3 <<< 1);
         h3_ff <= sf3 - (sf2 <<< 1) + sf;
         h4_ff <= sf3 - sf2;
      end
   end

   stage_en_type en;
   assign en.ld4 = ld[4];
   assign en.ld5 = ld[5];
   assign en.ld6 = ld[6];
   assign en.ld7 = ld[7];
   assign en.ld8 = ld[8];

   logic signed [COORD_BITS-1:0] res [3];

   for (genvar ax = 0; ax < 3; ax++) begin : g_axis
      csp_axis u_axis (
         .clock  (clock),
         .en     (en),
         .bend   (bend_ff),
         .p0     ($signed(rd_ff[0][ax*COORD_BITS +: COORD_BITS])),
         .p1     ($signed(rd_ff[1][ax*COORD_BITS +: COORD_BITS])),
         .p2     ($signed(rd_ff[2][ax*COORD_BITS +: COORD_BITS])),
         .pm     ($signed(rd_ff[3][ax*COORD_BITS +: COORD_BITS])),
         .h1     (h1_ff),
         .h2     (h2_ff),
         .h3     (h3_ff),
         .h4     (h4_ff),
         .result (res[ax])
      );
   end

   // valid bits; write items leave the pipe once stored
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[1]) v_ff[1] <= req_tvalid;
         if (ld[2]) v_ff[2] <= v_ff[1];
         if (ld[3]) v_ff[3] <= v_ff[2] && (func_2_ff == FUNC_EVAL);
         for (int k = 4; k <= 8; k++) if (ld[k]) v_ff[k] <= v_ff[k-1];
      end
   end

   assign rsp_tvalid = v_ff[8];
   assign rsp_tdata  = {res[2], res[1], res[0]};

endmodule

// ----- src/csp_checker.sv -----
// port-level checks for the cardinal spline point evaluator
module csp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   a_csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write refused");

endmodule

bind cardinal_spline_point_eval csp_checker u_csp_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench for the cardinal spline point evaluator
module tb_top;
   import csp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] z;
      logic [15:0] y;
      logic [15:0] x;
   } point_type;

   typedef struct {
      logic        func;
      logic [5:0]  idx;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] pz;
      logic [16:0] loc;
      logic        chk;   // typed-in expectation present
      point_type   want;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   cardinal_spline_point_eval u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   point_type   pts [64];
   logic [6:0]  num_pts;
   logic        closed;
   logic [15:0] bend;

   point_type   spline_q [$];
   int          errors = 0;
   longint      cycles = 0;
   int          hold_off = 0;
   bit          stall_en = 1'b1;

   function automatic logic signed [15:0] sat_axis(longint p0, longint p1, longint p2,
                                                   longint pm, longint h1, longint h2,
                                                   longint h3, longint h4);
      longint v1, v2, s, q;
      v1 = longint'(bend) * (p1 - pm);
      v2 = longint'(bend) * (p2 - p0);
      s = (h1 * p0 + h2 * p1) * 16384 + h3 * v1 + h4 * v2;
      q = (s < 0) ? -((-s) >>> 30) : (s >>> 30);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic point_type eval_spline(logic [16:0] loc_in);
      longint cnt, n, loc, prod, seg, rem, f, f2, f3, h1, h2, h3, h4;
      longint i0, i1, i2, i3;
      point_type r;
      cnt = num_pts;
      if (cnt == 0) cnt = 1;
      if (cnt > 64) cnt = 64;
      loc = loc_in;
      if (loc > 65536) loc = 65536;
      n = closed ? cnt : cnt - 1;
      prod = loc * n;
      seg = prod >> 16;
      rem = prod & 16'hFFFF;
      f = rem;
      if (closed) begin
         seg = seg % cnt;
         i0 = seg; i1 = (seg + 1) % cnt; i2 = (seg + 2) % cnt; i3 = (seg + cnt - 1) % cnt;
      end else begin
         if (seg > cnt - 1) seg = cnt - 1;
         i0 = seg;
         i1 = (seg + 1 > cnt - 1) ? cnt - 1 : seg + 1;
         i2 = (seg + 2 > cnt - 1) ? cnt - 1 : seg + 2;
         i3 = (seg == 0) ? 0 : seg - 1;
      end
      f2 = (f * f) >> 16;
      f3 = (f2 * f) >> 16;
      h1 = 2 * f3 - 3 * f2 + 65536;
      h2 = 3 * f2 - 2 * f3;
      h3 = f3 - 2 * f2 + f;
      h4 = f3 - f2;
      r.x = sat_axis($signed(pts[i0].x), $signed(pts[i1].x), $signed(pts[i2].x),
                     $signed(pts[i3].x), h1, h2, h3, h4);
      r.y = sat_axis($signed(pts[i0].y), $signed(pts[i1].y), $signed(pts[i2].y),
                     $signed(pts[i3].y), h1, h2, h3, h4);
      r.z = sat_axis($signed(pts[i0].z), $signed(pts[i1].z), $signed(pts[i2].z),
                     $signed(pts[i3].z), h1, h2, h3, h4);
      return r;
   endfunction

   // receiver: own stall pattern plus a long hold-off on request
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (!stall_en)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= (cycles % 37 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (!reset && rsp_tvalid && rsp_tready) begin
         point_type got, exp_pt;
         got = rsp_tdata;
         if (spline_q.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            exp_pt = spline_q.pop_front();
            if (got.x !== exp_pt.x) begin
               $error("out_x exp %h got %h", exp_pt.x, got.x); errors++;
            end
            if (got.y !== exp_pt.y) begin
               $error("out_y exp %h got %h", exp_pt.y, got.y); errors++;
            end
            if (got.z !== exp_pt.z) begin
               $error("out_z exp %h got %h", exp_pt.z, got.z); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > 3000000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NUM_POINTS:  num_pts = val[6:0];
         CSR_CLOSED_MODE: closed = val[0];
         CSR_BEND_SIZE:   bend = val;
         default: ;
      endcase
   endtask

   // send one item; valid stays high between back-to-back items
   task automatic send_item(stim_type s, bit keep);
      point_type exp_pt;
      req_tvalid <= 1'b1;
      req_tuser <= s.func;
      req_tdata <= {1'b0, s.loc, s.pz, s.py, s.px, s.idx};
      do @(posedge clock); while (!req_tready);
      if (!keep) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      if (s.func == FUNC_WRITE) begin
         pts[s.idx] = {s.pz, s.py, s.px};
      end else begin
         exp_pt = eval_spline(s.loc);
         if (s.chk && exp_pt !== s.want) begin
            $error("table row disagrees: typed %h computed %h", s.want, exp_pt);
            errors++;
         end
         spline_q.push_back(exp_pt);
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (spline_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (12) @(posedge clock);
   endtask

   function automatic stim_type mk_write(int idx, int x, int y, int z);
      stim_type s;
      s = '{FUNC_WRITE, idx[5:0], x[15:0], y[15:0], z[15:0], 17'($urandom()), 1'b0, '0};
      return s;
   endfunction

   function automatic stim_type mk_eval(int loc, bit chk, point_type want);
      stim_type s;
      s = '{FUNC_EVAL, 6'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
            loc[16:0], chk, want};
      return s;
   endfunction

   // random item over the first cnt slots, all of which are written
   function automatic stim_type rand_item(int cnt);
      stim_type s;
      int r;
      r = $urandom_range(0, 9);
      if (r < 3)
         s = mk_write($urandom_range(0, cnt - 1), $urandom(), $urandom(), $urandom());
      else if (r == 3)
         s = mk_eval($urandom_range(0, 2) == 0 ? 65536 + $urandom_range(0, 65535) :
                     $urandom_range(65530, 65536), 1'b0, '0);
      else
         s = mk_eval($urandom_range(0, 65536), 1'b0, '0);
      return s;
   endfunction

   stim_type dir_tab [$];

   initial begin
      int k, sent, ph, cnt, burst;
      num_pts = 1; closed = 1'b0; bend = 16'd8192;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single point after reset, extremes, clamping
      dir_tab.push_back(mk_write(0, 1000, -2000, 3000));
      dir_tab.push_back(mk_eval(0, 1'b1, {16'd3000, -16'sd2000, 16'd1000}));
      dir_tab.push_back(mk_eval(65536, 1'b1, {16'd3000, -16'sd2000, 16'd1000}));
      dir_tab.push_back(mk_eval(131071, 1'b1, {16'd3000, -16'sd2000, 16'd1000}));
      dir_tab.push_back(mk_write(0, 32767, -32768, 0));
      dir_tab.push_back(mk_eval(40000, 1'b1, {16'd0, 16'h8000, 16'h7FFF}));
      dir_tab.push_back(mk_write(1, -32768, 32767, -1));
      dir_tab.push_back(mk_write(2, 32767, -32768, 12345));
      dir_tab.push_back(mk_write(3, -32768, 32767, -12345));
      dir_tab.push_back(mk_write(63, 32767, 32767, 32767));
      foreach (dir_tab[i]) send_item(dir_tab[i], 1'b0);
      drain();

      for (k = 4; k < 64; k++) send_item(mk_write(k, $urandom(), $urandom(), $urandom()),
                                         1'b1);
      req_tvalid <= 1'b0;
      drain();

      // settings per phase: zero count, max count, over-range count, bend extremes
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin csr_write(CSR_NUM_POINTS, 16'd4); csr_write(CSR_CLOSED_MODE, 16'd0);
                     csr_write(CSR_BEND_SIZE, 16'hFFFF); end
            1: begin csr_write(CSR_CLOSED_MODE, 16'd1); end
            2: begin csr_write(CSR_NUM_POINTS, 16'd64); csr_write(CSR_BEND_SIZE, 16'd0); end
            3: begin csr_write(CSR_NUM_POINTS, 16'h007F); csr_write(CSR_CLOSED_MODE, 16'd0);
                     csr_write(CSR_BEND_SIZE, 16'd8192); end
            4: begin csr_write(CSR_NUM_POINTS, 16'd0); csr_write(CSR_CLOSED_MODE, 16'd1); end
            5: begin csr_write(CSR_NUM_POINTS, 16'd2); csr_write(CSR_BEND_SIZE, 16'hFFFF); end
            6: begin csr_write(CSR_NUM_POINTS, 16'd7); csr_write(CSR_CLOSED_MODE, 16'd0);
                     csr_write(CSR_BEND_SIZE, 16'($urandom())); end
            default: begin csr_write(CSR_NUM_POINTS, 16'd64); csr_write(CSR_CLOSED_MODE, 16'd1);
                     csr_write(CSR_BEND_SIZE, 16'hAAAA); end
         endcase
         cnt = (num_pts == 0) ? 1 : (num_pts > 64 ? 64 : num_pts);
         // directed endpoints per setting
         send_item(mk_eval(0, 1'b0, '0), 1'b0);
         send_item(mk_eval(65536, 1'b0, '0), 1'b0);
         if (ph == 2) begin
            // long receiver hold-off while the sender keeps going
            hold_off = 300;
            for (k = 0; k < 60; k++) send_item(mk_eval($urandom_range(0, 65536), 1'b0, '0),
                                               1'b1);
         end
         sent = 0;
         while (sent < 75) begin
            burst = $urandom_range(1, 12);
            stall_en = (ph != 5);
            for (k = 0; k < burst; k++) begin
               send_item(rand_item(cnt), k != burst - 1);
               sent++;
            end
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         drain();
      end

      if (spline_q.size() != 0) begin
         $error("expected results never arrived: %0d", spline_q.size());
         errors++;
      end
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
